// File: sv/sahr_pkg.sv
// Package for the six-axis idle-hold response block.
// Types, constants, codes and axis remap tables shared by the controller,
// datapath and top level. No dependencies.
package sahr_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 4;

    localparam int AXES       = 6;
    localparam int AXIS_IDX_W = 3;
    localparam int THR_W      = 4;
    localparam int GAIN_W     = 12;
    localparam int GAIN_SHIFT = 12;
    localparam int OUT_W      = 31;
    localparam int MAG_W      = 30;
    localparam int BTN_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 192;

    localparam logic [THR_W-1:0]  THR_RESET   = 4'd3;
    localparam logic [GAIN_W-1:0] TRANS_RESET = 12'd1049;
    localparam logic [GAIN_W-1:0] ROT_RESET   = 12'd839;
    localparam logic [MAG_W-1:0]  MAG_MAX     = '1;

    localparam logic [15:0] TYPE_KEY   = 16'd1;
    localparam logic [15:0] TYPE_REL   = 16'd2;
    localparam logic [15:0] BTN_FIRST  = 16'd256;
    localparam logic [15:0] BTN_SECOND = 16'd257;

    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SQ,
        ST_MUL,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic                  ev_write;
        logic                  update;
        logic                  sq;
        logic                  mul;
        logic                  load_out;
        logic [AXIS_IDX_W-1:0] idx;
    } dp_cmd_t;

    // output slot -> source axis (tx ty tz rx ry rz = 0..5)
    function automatic logic [AXIS_IDX_W-1:0] out_src(input logic [AXIS_IDX_W-1:0] k);
        logic [AXIS_IDX_W-1:0] s;
        case (k)
            3'd0:    s = 3'd0;
            3'd1:    s = 3'd2;
            3'd2:    s = 3'd1;
            3'd3:    s = 3'd3;
            3'd4:    s = 3'd5;
            3'd5:    s = 3'd4;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    function automatic logic out_negate(input logic [AXIS_IDX_W-1:0] k);
        return k inside {3'd1, 3'd2, 3'd4, 3'd5};
    endfunction

    function automatic logic out_is_rot(input logic [AXIS_IDX_W-1:0] k);
        return k >= 3'd3;
    endfunction

endpackage

// File: sv/sahr_ctrl.sv
// Controller for the six-axis idle-hold response block.
// Sequences the frame-end update and the per-axis multiply steps; owns the
// output valid flag. Depends on sahr_pkg.
module sahr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              frame_cmd,
    output logic              m_tvalid,
    input  logic              m_tready,
    output sahr_pkg::dp_cmd_t cmd
);
    import sahr_pkg::*;

    ctrl_state_t           state_reg, state_next;
    logic [AXIS_IDX_W-1:0] idx_reg, idx_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.idx      = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (frame_cmd == CMD_FRAME)
                        state_next = ST_UPDATE;
                    else
                        cmd.ev_write = 1'b1;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                idx_next   = '0;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                if (idx_reg == AXIS_IDX_W'(AXES - 1))
                    state_next = ST_DONE;
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SQ;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// File: sv/sahr_dp.sv
// Datapath for the six-axis idle-hold response block.
// Config registers, axis/button state, idle counters, square and gain
// multipliers shared by all axes, result staging and output register. Depends on sahr_pkg.
module sahr_dp #(
    parameter int VALUE_BITS = sahr_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = sahr_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sahr_pkg::dp_cmd_t                cmd,
    input  logic [sahr_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             cfg_write,
    input  logic [sahr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sahr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [sahr_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import sahr_pkg::*;

    localparam int MAGV_W  = VALUE_BITS - 1;
    localparam int SQ_W    = 2 * MAGV_W;
    localparam int PROD_W  = SQ_W + GAIN_W;
    localparam int RW      = (SQ_W > OUT_W) ? SQ_W : OUT_W;
    localparam int CMP_W   = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
    localparam int LIM     = (1 << (VALUE_BITS - 1)) - 1;
    localparam int PAY_W   = AXES * OUT_W + 2 * BTN_W;

    logic [THR_W-1:0]  thr_reg;
    logic [GAIN_W-1:0] trans_reg;
    logic [GAIN_W-1:0] rot_reg;

    logic signed [VALUE_BITS-1:0] axis_reg [AXES];
    logic [COUNT_BITS-1:0]        cnt_reg  [AXES];
    logic [AXES-1:0]              active_reg;
    logic [BTN_W-1:0]             btn0_reg, btn1_reg;

    logic [SQ_W-1:0]   sq_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              neg_reg;
    logic [OUT_W-1:0]  res_reg [AXES];
    logic [PAY_W-1:0]  out_reg;

    // event decode
    logic [15:0]          ev_type, ev_code;
    logic signed [31:0]   ev_val;
    logic [BTN_W-1:0]     btn_clamp;
    logic signed [31:0]   val_sat;

    assign ev_type = s_tdata[15:0];
    assign ev_code = s_tdata[31:16];
    assign ev_val  = s_tdata[63:32];

    always_comb
    begin
        if (ev_val < 0)
            btn_clamp = 2'd0;
        else if (ev_val > 32'sd2)
            btn_clamp = 2'd2;
        else
            btn_clamp = ev_val[BTN_W-1:0];

        if (ev_val > LIM)
            val_sat = LIM;
        else if (ev_val < -LIM)
            val_sat = -LIM;
        else
            val_sat = ev_val;
    end

    // frame-end idle update, one lane per axis
    logic [COUNT_BITS-1:0] cnt_upd [AXES];
    logic [AXES-1:0]       clear_ax;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            if (active_reg[i])
                cnt_upd[i] = '0;
            else if (cnt_reg[i] != '1)
                cnt_upd[i] = cnt_reg[i] + 1'b1;
            else
                cnt_upd[i] = cnt_reg[i];
            clear_ax[i] = CMP_W'(cnt_upd[i]) >= CMP_W'(thr_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THR_RESET;
            trans_reg <= TRANS_RESET;
            rot_reg   <= ROT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_IDLE_THR: thr_reg   <= cfg_data[THR_W-1:0];
                CFG_TRANS:    trans_reg <= cfg_data[GAIN_W-1:0];
                CFG_ROT:      rot_reg   <= cfg_data[GAIN_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                axis_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            active_reg <= '0;
            btn0_reg   <= '0;
            btn1_reg   <= '0;
        end
        else if (cmd.ev_write)
        begin
            if (ev_type == TYPE_KEY && ev_code == BTN_FIRST)
                btn0_reg <= btn_clamp;
            else if (ev_type == TYPE_KEY && ev_code == BTN_SECOND)
                btn1_reg <= btn_clamp;
            else if (ev_type == TYPE_REL && ev_code < 16'(AXES))
            begin
                axis_reg[ev_code[AXIS_IDX_W-1:0]]   <= val_sat[VALUE_BITS-1:0];
                active_reg[ev_code[AXIS_IDX_W-1:0]] <= 1'b1;
            end
        end
        else if (cmd.update)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                cnt_reg[i] <= cnt_upd[i];
                if (clear_ax[i])
                    axis_reg[i] <= '0;
            end
            active_reg <= '0;
        end
    end

    // square step
    logic signed [VALUE_BITS-1:0] sel_v;
    logic [VALUE_BITS-1:0]        sel_abs;
    logic [MAGV_W-1:0]            sel_mag;
    logic [SQ_W-1:0]              sq_val;

    assign sel_v   = axis_reg[out_src(cmd.idx)];
    assign sel_abs = sel_v[VALUE_BITS-1] ? VALUE_BITS'(-sel_v) : VALUE_BITS'(sel_v);
    assign sel_mag = sel_abs[MAGV_W-1:0];
    assign sq_val  = sel_mag * sel_mag;

    always_ff @(posedge clk)
    begin
        if (cmd.sq)
        begin
            sq_reg   <= sq_val;
            gain_reg <= out_is_rot(cmd.idx) ? rot_reg : trans_reg;
            neg_reg  <= sel_v[VALUE_BITS-1] ^ out_negate(cmd.idx);
        end
    end

    // gain step, scale and saturate
    logic [PROD_W-1:0] prod;
    logic [RW-1:0]     r_ext;
    logic [MAG_W-1:0]  mag_sat;
    logic [OUT_W-1:0]  res_val;

    assign prod    = PROD_W'(sq_reg) * PROD_W'(gain_reg);
    assign r_ext   = RW'(prod[PROD_W-1:GAIN_SHIFT]);
    assign mag_sat = (r_ext > RW'(MAG_MAX)) ? MAG_MAX : r_ext[MAG_W-1:0];
    assign res_val = neg_reg ? -{1'b0, mag_sat} : {1'b0, mag_sat};

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            res_reg[cmd.idx] <= res_val;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            out_reg <= {btn1_reg, btn0_reg, res_reg[5], res_reg[4], res_reg[3],
                        res_reg[2], res_reg[1], res_reg[0]};
    end

    assign m_tdata = OUT_DATA_W'(out_reg);

endmodule

// File: sv/six_axis_idle_hold_response.sv
// Six-axis idle-hold response: event latch, idle hold and squared responses.
// Event items are accepted whenever the block is idle. A frame-end item
// occupies the block for one idle update, then six axes of square and gain
// steps on multipliers shared by all axes; the result is valid once the
// output register is loaded, later only while the previous result still waits there.
// Events are taken while a result waits on the output register.
// Reset (rst_n low, asynchronous): state cleared, registers to defaults.
module six_axis_idle_hold_response #(
    parameter int VALUE_BITS = sahr_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = sahr_pkg::COUNT_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // event_type[15:0], event_code[31:16], event_value[63:32]
    input  logic [sahr_pkg::IN_DATA_W-1:0]   s_tdata,
    // command[0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_tx[30:0], out_ty[61:31], out_tz[92:62], out_rx[123:93],
    // out_ry[154:124], out_rz[185:155], button_first[187:186],
    // button_second[189:188], zero fill[191:190]
    output logic [sahr_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sahr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sahr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sahr_pkg::*;

    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    sahr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .frame_cmd (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd)
    );

    sahr_dp #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

    a_frame_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == CMD_FRAME) |=> !s_tready)
        else $error("block ready straight after frame-end item");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> m_tvalid)
        else $error("output load without valid");

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.ev_write, cmd.update, cmd.sq, cmd.mul, cmd.load_out}))
        else $error("datapath commands overlap");

    a_sq_then_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sq |=> (cmd.mul && cmd.idx == $past(cmd.idx)))
        else $error("square step not followed by gain step");

endmodule
